@@ hw/rtl/abpm_pkg.sv @@
// Shared blend-mode codes, lane control type and divide-by-255 helper.
`default_nettype none

package abpm_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned NUM_CHAN = 4;
   localparam int unsigned PIXEL_W  = CHAN_W * NUM_CHAN;
   localparam int unsigned PROD_W   = 2 * CHAN_W;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_ADD      = 3'd1,
      MODE_SUBTRACT = 3'd2,
      MODE_MULTIPLY = 3'd3,
      MODE_SCREEN   = 3'd4,
      MODE_DARKEN   = 3'd5,
      MODE_LIGHTEN  = 3'd6,
      MODE_PASS     = 3'd7
   } mode_type;

   typedef struct packed {
      logic load_prod;
   } lane_ctl_type;

   // Exact truncating x / 255 for any x up to 255 * 255.
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] t;
      t = {1'b0, x} + {{PROD_W{1'b0}}, 1'b1} + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]};
      return t[PROD_W-1:CHAN_W];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/abpm_lane.sv @@
// One color channel lane: product stage register and final per-mode selection.
`default_nettype none

module abpm_lane
   import abpm_pkg::*;
(
   input  wire logic              clock,
   input  wire mode_type          mode,
   input  wire lane_ctl_type      ctl,
   input  wire logic [CHAN_W-1:0] src_chan,
   input  wire logic [CHAN_W-1:0] dst_chan,
   input  wire logic [CHAN_W-1:0] src_alpha,
   output logic      [CHAN_W-1:0] chan_result
);

   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;
   logic [CHAN_W-1:0] src_ff;
   logic [CHAN_W-1:0] dst_ff;
   logic [CHAN_W-1:0] quot;
   logic [CHAN_W:0]   sum;

   // The one product (or weighted sum) the mode needs, sized to 16 bits.
   always_comb begin
      unique case (mode) inside
         MODE_NORMAL: begin
            prod_in = PROD_W'(src_chan) * PROD_W'(src_alpha)
                    + PROD_W'(dst_chan) * PROD_W'(CHAN_MAX - src_alpha);
         end
         MODE_ADD, MODE_SUBTRACT: begin
            prod_in = PROD_W'(src_chan) * PROD_W'(src_alpha);
         end
         MODE_MULTIPLY: begin
            prod_in = PROD_W'(src_chan) * PROD_W'(dst_chan);
         end
         MODE_SCREEN: begin
            prod_in = PROD_W'(CHAN_MAX - src_chan) * PROD_W'(CHAN_MAX - dst_chan);
         end
         default: begin
            prod_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_ff <= prod_in;
         src_ff  <= src_chan;
         dst_ff  <= dst_chan;
      end
   end

   assign quot = div255(prod_ff);
   assign sum  = {1'b0, quot} + {1'b0, dst_ff};

   always_comb begin
      unique case (mode)
         MODE_NORMAL:   chan_result = quot;
         MODE_ADD:      chan_result = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
         MODE_SUBTRACT: chan_result = (quot > dst_ff) ? '0 : dst_ff - quot;
         MODE_MULTIPLY: chan_result = quot;
         MODE_SCREEN:   chan_result = CHAN_MAX - quot;
         MODE_DARKEN:   chan_result = (src_ff < dst_ff) ? src_ff : dst_ff;
         MODE_LIGHTEN:  chan_result = (src_ff > dst_ff) ? src_ff : dst_ff;
         MODE_PASS:     chan_result = src_ff;
         default:       chan_result = src_ff;
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/argb_pixel_blend_modes_unit.sv @@
// Top level of the ARGB8888 blend unit: handshake pipeline, four lanes, output merge.
`default_nettype none

// Blends a packed ARGB8888 source color onto a packed ARGB8888 destination
// pixel, treating alpha, red, green and blue alike, under the blend mode held
// in the mode register (normal, additive with saturation, subtractive clamped
// at zero, multiply, screen, darken, lighten, or source pass-through). Every
// division is by 255 and truncates. One transaction is accepted per clock
// cycle when the result side keeps up. The product stage registers each
// channel's product (a weighted sum in normal mode), formed in one of four
// parallel lanes; the output stage divides by 255, applies the mode's final
// step and registers the merged pixel. The mode register may only be
// written while no transaction is in flight.

module argb_pixel_blend_modes_unit
   import abpm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // Configuration
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_wdata,
   // Input channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // [31:0] src_color, [63:32] dst_color
   // Result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata    // [31:0] out_color
);

   mode_type           mode_ff;
   logic               prod_valid_ff;
   logic               prod_valid_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [PIXEL_W-1:0] out_color_ff;
   logic [PIXEL_W-1:0] merged;
   logic               out_ready;
   logic               prod_ready;
   logic               load_out;
   lane_ctl_type       lane_ctl;

   logic [PIXEL_W-1:0] src_color;
   logic [PIXEL_W-1:0] dst_color;

   assign src_color = req_tdata[PIXEL_W-1:0];
   assign dst_color = req_tdata[2*PIXEL_W-1:PIXEL_W];

   // The mode register. Only the low three bits of a write exist.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else if (csr_we) begin
         mode_ff <= mode_type'(csr_wdata);
      end
   end

   // Each stage may load when it is empty or when the stage after it is
   // draining in the same cycle, so the pipeline flows at one transaction
   // per cycle and holds its contents under back-pressure.
   assign out_ready          = !out_valid_ff || rsp_tready;
   assign prod_ready         = !prod_valid_ff || out_ready;
   assign req_tready         = prod_ready;
   assign lane_ctl.load_prod = req_tvalid && prod_ready;
   assign load_out           = prod_valid_ff && out_ready;

   always_comb begin
      if (lane_ctl.load_prod) begin
         prod_valid_in = 1'b1;
      end else if (out_ready) begin
         prod_valid_in = 1'b0;
      end else begin
         prod_valid_in = prod_valid_ff;
      end
   end

   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // One lane per channel; every lane weights by the source alpha.
   for (genvar lane = 0; lane < NUM_CHAN; lane++) begin : g_lane
      abpm_lane u_lane (
         .clock       (clock),
         .mode        (mode_ff),
         .ctl         (lane_ctl),
         .src_chan    (src_color[lane*CHAN_W +: CHAN_W]),
         .dst_chan    (dst_color[lane*CHAN_W +: CHAN_W]),
         .src_alpha   (src_color[PIXEL_W-1 -: CHAN_W]),
         .chan_result (merged[lane*CHAN_W +: CHAN_W])
      );
   end

   // Merge stage: the four channel results are packed back into one pixel.
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_color_ff <= merged;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_color_ff;

endmodule

`default_nettype wire
